// ===== rtl/core/ttac_pkg.sv =====
// Shared types, constants and ROM for the thermistor averaging/conversion block.
// No dependencies; imported by every module of the block.
`default_nettype none

package ttac_pkg;

   localparam int TABLE_ENTRIES = 20;
   localparam int FRACTION_BITS = 6;

   localparam int ADC_W    = 10;
   localparam int SUM_W    = 18;
   localparam int CNT_W    = 8;
   localparam int OUT_W    = 16;
   localparam int ROM_W    = 10;
   localparam int SEG_W    = $clog2(TABLE_ENTRIES);
   localparam int DIV_W    = 26;
   localparam int DIVSR_W  = 10;
   localparam int DCNT_W   = $clog2(DIV_W);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CNT_W-1:0] SAMPLE_COUNT_RESET = 8'd10;

   // ADC point / whole degrees C pairs
   localparam logic [ROM_W-1:0] ROM_X [TABLE_ENTRIES] = '{
      10'd1,   10'd54,  10'd107, 10'd160, 10'd213, 10'd266, 10'd319,
      10'd372, 10'd425, 10'd478, 10'd531, 10'd584, 10'd637, 10'd690,
      10'd743, 10'd796, 10'd849, 10'd902, 10'd955, 10'd1008
   };
   localparam logic [ROM_W-1:0] ROM_Y [TABLE_ENTRIES] = '{
      10'd864, 10'd258, 10'd211, 10'd185, 10'd168, 10'd154, 10'd143,
      10'd133, 10'd125, 10'd116, 10'd109, 10'd101, 10'd94,  10'd87,
      10'd79,  10'd70,  10'd61,  10'd50,  10'd34,  10'd2
   };

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } ttac_batch_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [DIVSR_W-1:0] divisor;
   } ttac_div_req_type;

   function automatic logic [OUT_W-1:0] rom_x_scaled(input logic [SEG_W-1:0] idx);
      logic [OUT_W-1:0] v;
      v = OUT_W'(ROM_X[idx]);
      return v << FRACTION_BITS;
   endfunction

   function automatic logic [OUT_W-1:0] rom_y_scaled(input logic [SEG_W-1:0] idx);
      logic [OUT_W-1:0] v;
      v = OUT_W'(ROM_Y[idx]);
      return v << FRACTION_BITS;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ttac_front.sv =====
// Front end: sample-count register and running sum; hands completed batches on.
// Depends on ttac_pkg.
`default_nettype none

module ttac_front
   import ttac_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_en,
   input  wire logic [CNT_W-1:0]     csr_write_data,
   input  wire logic                 req_push,
   input  wire logic [ADC_W-1:0]     req_adc_sample,
   input  wire logic                 q_full,
   output      logic                 req_full,
   output      logic                 q_push,
   output      ttac_batch_type       q_batch
);

   logic [CNT_W-1:0] count_ff;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] taken_ff, taken_in;
   logic [CNT_W-1:0] target;
   logic             accept, last;

   always_comb begin
      target   = (count_ff == '0) ? CNT_W'(1) : count_ff;
      sum_in   = sum_ff + SUM_W'(req_adc_sample);
      taken_in = taken_ff + CNT_W'(1);
      accept   = req_push && !q_full;
      last     = taken_in >= target;
      q_push   = accept && last;
      q_batch.sum   = sum_in;
      q_batch.count = taken_in;
      req_full = q_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= SAMPLE_COUNT_RESET;
         sum_ff   <= '0;
         taken_ff <= '0;
      end else begin
         if (csr_write_en) begin
            count_ff <= csr_write_data;
         end
         if (accept) begin
            if (last) begin
               sum_ff   <= '0;
               taken_ff <= '0;
            end else begin
               sum_ff   <= sum_in;
               taken_ff <= taken_in;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ttac_queue.sv =====
// Short batch queue between the accumulator and the conversion engine.
// Depends on ttac_pkg.
`default_nettype none

module ttac_queue
   import ttac_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire ttac_batch_type push_data,
   input  wire logic           pop,
   output      logic           full,
   output      logic           empty,
   output      ttac_batch_type pop_data
);

   ttac_batch_type     mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QLVL_W-1:0]  level_ff;
   logic               do_push, do_pop;

   always_comb begin
      full     = level_ff == QLVL_W'(QUEUE_DEPTH);
      empty    = level_ff == '0;
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         if (do_push && !do_pop) begin
            level_ff <= level_ff + QLVL_W'(1);
         end else if (do_pop && !do_push) begin
            level_ff <= level_ff - QLVL_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ttac_div.sv =====
// Restoring divider, one quotient bit per cycle; shared by average and interpolation.
// Depends on ttac_pkg.
`default_nettype none

module ttac_div
   import ttac_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ttac_div_req_type req,
   output      logic             done,
   output      logic [DIV_W-1:0] quotient
);

   logic               busy_ff;
   logic               done_ff;
   logic [DCNT_W-1:0]  cnt_ff;
   logic [DIVSR_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0]   quo_ff;
   logic [DIVSR_W-1:0] dsr_ff;
   logic [DIVSR_W:0]   rem_sh;
   logic               ge;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[DIV_W-1]};
      ge       = rem_sh >= {1'b0, dsr_ff};
      rem_in   = ge ? DIVSR_W'(rem_sh - {1'b0, dsr_ff}) : rem_sh[DIVSR_W-1:0];
      done     = done_ff;
      quotient = quo_ff;
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dsr_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + DCNT_W'(1);
            if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ttac_back.sv =====
// Back end: average, table segment scan, interpolation and the result register.
// Depends on ttac_pkg; drives the shared divider ttac_div.
`default_nettype none

module ttac_back
   import ttac_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  wire ttac_batch_type   q_data,
   output      logic             q_pop,
   output      ttac_div_req_type div_req,
   input  wire logic             div_done,
   input  wire logic [DIV_W-1:0] div_quo,
   output      logic             rsp_empty,
   input  wire logic             rsp_pop,
   output      logic [OUT_W-1:0] rsp_temperature_q6,
   output      logic [OUT_W-1:0] rsp_average_q6
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_AVG    = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_MUL    = 6'b001000,
      ST_INTERP = 6'b010000,
      ST_EMIT   = 6'b100000
   } ttac_state_type;

   ttac_state_type    state_ff;
   logic [OUT_W-1:0]  avg_ff, temp_ff, diff_ff;
   logic [SEG_W-1:0]  seg_ff, seg_nxt;
   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_temp_ff, rsp_avg_ff;

   logic [OUT_W-1:0]   avg_new, q16, xa, xb, base, x_first, x_last;
   logic [ROM_W-1:0]   ya, yb, dy_mag, dx;
   logic               dy_neg, hit, out_free;
   logic [DIV_W-1:0]   prod;

   always_comb begin
      seg_nxt  = (seg_ff == SEG_W'(TABLE_ENTRIES - 1)) ? seg_ff : seg_ff + SEG_W'(1);
      xa       = rom_x_scaled(seg_ff);
      xb       = rom_x_scaled(seg_nxt);
      base     = rom_y_scaled(seg_ff);
      ya       = ROM_Y[seg_ff];
      yb       = ROM_Y[seg_nxt];
      dy_neg   = yb < ya;
      dy_mag   = dy_neg ? ya - yb : yb - ya;
      dx       = ROM_X[seg_nxt] - ROM_X[seg_ff];
      hit      = (xa < avg_ff) && (avg_ff <= xb);
      prod     = DIV_W'(diff_ff) * DIV_W'(dy_mag);
      x_first  = rom_x_scaled('0);
      x_last   = rom_x_scaled(SEG_W'(TABLE_ENTRIES - 1));
      avg_new  = div_quo[OUT_W-1:0];
      q16      = div_quo[OUT_W-1:0];
      out_free = !rsp_valid_ff || rsp_pop;

      q_pop            = (state_ff == ST_IDLE) && !q_empty;
      div_req.start    = q_pop || (state_ff == ST_MUL);
      div_req.dividend = DIV_W'(q_data.sum) << FRACTION_BITS;
      div_req.divisor  = DIVSR_W'(q_data.count);
      if (state_ff == ST_MUL) begin
         div_req.dividend = prod;
         div_req.divisor  = DIVSR_W'(dx);
      end

      rsp_empty          = !rsp_valid_ff;
      rsp_temperature_q6 = rsp_temp_ff;
      rsp_average_q6     = rsp_avg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) state_ff <= ST_AVG;
            end
            ST_AVG: begin
               if (div_done) begin
                  avg_ff <= avg_new;
                  seg_ff <= '0;
                  if (avg_new <= x_first) begin
                     temp_ff  <= rom_y_scaled('0);
                     state_ff <= ST_EMIT;
                  end else if (avg_new >= x_last) begin
                     temp_ff  <= rom_y_scaled(SEG_W'(TABLE_ENTRIES - 1));
                     state_ff <= ST_EMIT;
                  end else begin
                     state_ff <= ST_SCAN;
                  end
               end
            end
            ST_SCAN: begin
               if (hit) begin
                  diff_ff <= avg_ff - xa;
                  if (dx == '0) begin
                     temp_ff  <= base;
                     state_ff <= ST_EMIT;
                  end else begin
                     state_ff <= ST_MUL;
                  end
               end else begin
                  seg_ff <= seg_nxt;
               end
            end
            ST_MUL: begin
               state_ff <= ST_INTERP;
            end
            ST_INTERP: begin
               if (div_done) begin
                  temp_ff  <= dy_neg ? base - q16 : base + q16;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && out_free) begin
         rsp_temp_ff <= temp_ff;
         rsp_avg_ff  <= avg_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/thermistor_table_average_convert_top.sv =====
// Top level of the thermistor averaging and table conversion block.
// Depends on ttac_pkg, ttac_front, ttac_queue, ttac_div and ttac_back.
//
// Each ADC item is taken while full is low and added to a running sum; full is high only
// while two finished batches are already queued. After sample_count items (0 acts
// as 1) the batch goes to the conversion engine. When the average is clamped to a
// table end the result is emitted after the average pass; otherwise it needs two
// passes of the one shared restoring divider (load plus 26 quotient bits; average,
// then interpolation quotient), a table segment scan and a multiply state.
// The result waits in an output register until popped while the next batch proceeds.
`default_nettype none

module thermistor_table_average_convert_top
   import ttac_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_en,
   input  wire logic [CNT_W-1:0] csr_write_data,
   input  wire logic             req_push,
   output      logic             req_full,
   input  wire logic [ADC_W-1:0] req_adc_sample,
   output      logic             rsp_empty,
   input  wire logic             rsp_pop,
   output      logic [OUT_W-1:0] rsp_temperature_q6,
   output      logic [OUT_W-1:0] rsp_average_q6
);

   logic             q_push, q_full, q_empty, q_pop;
   ttac_batch_type   q_in, q_out;
   ttac_div_req_type div_req;
   logic             div_done;
   logic [DIV_W-1:0] div_quo;

   ttac_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_push       (req_push),
      .req_adc_sample (req_adc_sample),
      .q_full         (q_full),
      .req_full       (req_full),
      .q_push         (q_push),
      .q_batch        (q_in)
   );

   ttac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .full      (q_full),
      .empty     (q_empty),
      .pop_data  (q_out)
   );

   ttac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   ttac_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_data             (q_out),
      .q_pop              (q_pop),
      .div_req            (div_req),
      .div_done           (div_done),
      .div_quo            (div_quo),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_temperature_q6 (rsp_temperature_q6),
      .rsp_average_q6     (rsp_average_q6)
   );

endmodule

`default_nettype wire

// ===== rtl/core/ttac_checker.sv =====
// Port-level checks for the thermistor averaging and table conversion block.
// Depends on ttac_pkg; bound to thermistor_table_average_convert_top.
`default_nettype none

module ttac_checker
   import ttac_pkg::*;
(
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             csr_write_en,
   input wire logic [CNT_W-1:0] csr_write_data,
   input wire logic             req_push,
   input wire logic             req_full,
   input wire logic [ADC_W-1:0] req_adc_sample,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input wire logic [OUT_W-1:0] rsp_temperature_q6,
   input wire logic [OUT_W-1:0] rsp_average_q6
);

   a_reset_clears: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("result or full flag survives reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_temperature_q6)
                                && $stable(rsp_average_q6))
      else $error("waiting result item changed");

   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_temperature_q6 <= 16'd55296 && rsp_temperature_q6 >= 16'd128)
      else $error("temperature outside table range");

   a_low_clamp: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_average_q6 <= 16'd64 |-> rsp_temperature_q6 == 16'd55296)
      else $error("low average not clamped to first table temperature");

   a_avg_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_average_q6 <= 16'd65472)
      else $error("average above full-scale reading");

endmodule

bind thermistor_table_average_convert_top ttac_checker u_ttac_checker (.*);

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking bench for thermistor_table_average_convert_top: averaging, table interpolation.
// Holds its own averaging and interpolation predictor; needs only ttac_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_top;
   import ttac_pkg::*;

   localparam int DRAIN_CYCLES = 150;

   // ADC point / whole degrees C breakpoints
   localparam int TABLE_ADC [TABLE_ENTRIES] = '{
      1, 54, 107, 160, 213, 266, 319, 372, 425, 478,
      531, 584, 637, 690, 743, 796, 849, 902, 955, 1008
   };
   localparam int TABLE_DEGC [TABLE_ENTRIES] = '{
      864, 258, 211, 185, 168, 154, 143, 133, 125, 116,
      109, 101, 94, 87, 79, 70, 61, 50, 34, 2
   };

   localparam logic [ADC_W-1:0] EDGE_SAMPLES [12] = '{
      10'd0, 10'd1, 10'd2, 10'd54, 10'd55, 10'd1007,
      10'd1008, 10'd1023, 10'd106, 10'd107, 10'd341, 10'd682
   };

   typedef struct packed {
      logic [OUT_W-1:0] temp;
      logic [OUT_W-1:0] avg;
   } reading_type;

   class reading_board_type;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] taken;
      logic [CNT_W-1:0] count;
      reading_type      pending[$];
      int               errors;

      function new();
         sum    = '0;
         taken  = '0;
         count  = SAMPLE_COUNT_RESET;
         errors = 0;
      endfunction

      function void set_count(logic [CNT_W-1:0] v);
         count = v;
      endfunction

      function logic [OUT_W-1:0] to_temperature(longint a);
         longint xa, xb, ya, yb, dx, q;
         if (a <= (longint'(TABLE_ADC[0]) << FRACTION_BITS))
            return OUT_W'(longint'(TABLE_DEGC[0]) << FRACTION_BITS);
         if (a >= (longint'(TABLE_ADC[TABLE_ENTRIES-1]) << FRACTION_BITS))
            return OUT_W'(longint'(TABLE_DEGC[TABLE_ENTRIES-1]) << FRACTION_BITS);
         for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
            xa = longint'(TABLE_ADC[i]) << FRACTION_BITS;
            xb = longint'(TABLE_ADC[i+1]) << FRACTION_BITS;
            if (xa < a && a <= xb) begin
               ya = TABLE_DEGC[i];
               yb = TABLE_DEGC[i+1];
               dx = TABLE_ADC[i+1] - TABLE_ADC[i];
               if (dx == 0)
                  return OUT_W'(ya << FRACTION_BITS);
               q = ((a - xa) * (yb - ya)) / dx;
               return OUT_W'((ya << FRACTION_BITS) + q);
            end
         end
         return OUT_W'(longint'(TABLE_DEGC[TABLE_ENTRIES-1]) << FRACTION_BITS);
      endfunction

      function void note_reading(logic [ADC_W-1:0] adc);
         logic [CNT_W-1:0] goal;
         longint           avg;
         reading_type      r;
         sum   = SUM_W'(sum + adc);
         taken = CNT_W'(taken + 1);
         goal  = (count == 0) ? CNT_W'(1) : count;
         if (taken < goal)
            return;
         avg    = (longint'(sum) << FRACTION_BITS) / longint'(taken);
         r.temp = to_temperature(avg);
         r.avg  = OUT_W'(avg);
         pending.push_back(r);
         sum   = '0;
         taken = '0;
      endfunction

      function void check_result(logic [OUT_W-1:0] temp, logic [OUT_W-1:0] avg);
         reading_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result: temperature %0d average %0d", $time, temp, avg);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (temp !== e.temp) begin
            $display("%0t: temperature expected %0d got %0d", $time, e.temp, temp);
            errors++;
         end
         if (avg !== e.avg) begin
            $display("%0t: average expected %0d got %0d", $time, e.avg, avg);
            errors++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_write_en = 1'b0;
   logic [CNT_W-1:0] csr_write_data = '0;
   logic             req_push = 1'b0;
   logic             req_full;
   logic [ADC_W-1:0] req_adc_sample = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   logic [OUT_W-1:0] rsp_temperature_q6;
   logic [OUT_W-1:0] rsp_average_q6;

   reading_board_type board;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                centre = 512;

   thermistor_table_average_convert_top dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_adc_sample     (req_adc_sample),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_temperature_q6 (rsp_temperature_q6),
      .rsp_average_q6     (rsp_average_q6)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full)
            board.note_reading(req_adc_sample);
         if (rsp_pop && !rsp_empty)
            board.check_result(rsp_temperature_q6, rsp_average_q6);
      end
   end

   task automatic send_reading(logic [ADC_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_adc_sample <= v;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (board.pending.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_sample_count(logic [CNT_W-1:0] v);
      req_push <= 1'b0;
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      board.set_count(v);
      csr_write_en   <= 1'b0;
   endtask

   // readings cluster round a wandering centre so averages cover every segment
   function automatic logic [ADC_W-1:0] next_sample();
      int r;
      int v;
      r = $urandom_range(99);
      if ($urandom_range(7) == 0)
         centre = $urandom_range(1023);
      if (r < 8)
         return ADC_W'($urandom_range(1023));
      if (r < 12)
         return r[0] ? ADC_W'(1023) : ADC_W'(0);
      v = centre + $urandom_range(16) - 8;
      if (v < 0)
         v = 0;
      if (v > 1023)
         v = 1023;
      return ADC_W'(v);
   endfunction

   initial begin
      int               r;
      int               n;
      logic [CNT_W-1:0] cnt;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 9;
      recv_idle_pct = 84;

      // count after reset
      for (int i = 0; i < 5; i++)
         send_reading(10'd1023);
      for (int i = 0; i < 5; i++)
         send_reading(10'd0);

      set_sample_count(8'd1);
      foreach (EDGE_SAMPLES[i])
         send_reading(EDGE_SAMPLES[i]);

      // zero count acts as one
      set_sample_count(8'd0);
      send_reading(10'd513);
      send_reading(10'd1);

      // count lowered with a part-filled batch
      set_sample_count(8'd8);
      for (int i = 0; i < 5; i++)
         send_reading(ADC_W'($urandom_range(1023)));
      set_sample_count(8'd2);
      send_reading(10'd700);

      for (int seg = 0; seg < 12; seg++) begin
         if (seg < 4) begin
            send_idle_pct = 9;
            recv_idle_pct = 84;
         end else if (seg < 8) begin
            send_idle_pct = 84;
            recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         r = $urandom_range(99);
         if (seg == 3)
            cnt = 8'd255;
         else if (seg == 9)
            cnt = 8'd1;
         else if (r < 40)
            cnt = CNT_W'($urandom_range(4, 1));
         else if (r < 70)
            cnt = CNT_W'($urandom_range(16, 5));
         else if (r < 80)
            cnt = 8'd0;
         else
            cnt = CNT_W'($urandom_range(254, 17));
         set_sample_count(cnt);
         n = 90;
         if (seg == 3) begin
            // full-scale batch: largest sum
            for (int i = 0; i < 255; i++)
               send_reading(10'd1023);
         end
         for (int i = 0; i < n; i++)
            send_reading(next_sample());
      end

      req_push <= 1'b0;
      wait_drained();
      if (board.errors == 0)
         $display("[thermistor_table_average_convert_top] OK");
      else
         $display("[thermistor_table_average_convert_top] ERROR");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[thermistor_table_average_convert_top] ERROR");
      $finish;
   end

endmodule

// ===== thermistor_table_average_convert_top.f =====
rtl/core/ttac_pkg.sv
rtl/core/ttac_front.sv
rtl/core/ttac_queue.sv
rtl/core/ttac_div.sv
rtl/core/ttac_back.sv
rtl/core/thermistor_table_average_convert_top.sv
rtl/core/ttac_checker.sv
dv/tb_top.sv
